// ===== design/tafr_pkg.sv =====
package tafr_pkg;

   // Field widths
   localparam int TIME_BITS     = 48;
   localparam int DURATION_BITS = 32;
   localparam int LEVEL_BITS    = 8;
   localparam int DIST_BITS     = LEVEL_BITS + 1;

   // Elapsed time is held wide enough to compare against either field
   localparam int CMP_W  = (TIME_BITS > DURATION_BITS) ? TIME_BITS : DURATION_BITS;
   // Quotient bits: the quotient stays below the distance magnitude
   localparam int QUOT_W = DIST_BITS;
   localparam int PROD_W = DURATION_BITS + DIST_BITS;
   localparam int DIVR_W = DURATION_BITS + QUOT_W - 1;
   localparam int CNT_W  = $clog2(QUOT_W);

   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 8'hFF;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_FADE  = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_SET   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_DIV,
      ST_ROUND,
      ST_OUT
   } state_type;

endpackage

// ===== design/timed_alpha_fade_ramp_top.sv =====
// Linear alpha fade ramp. Each accepted beat (tick, start fade, stop or direct set)
// yields exactly one result beat carrying the alpha level, a changed flag, a fade
// done pulse and the fading flag. Start fade, stop, direct set and a tick outside a
// fade go from the execute state straight to the output state. A tick that ends a
// fade passes through execute, check and output. A tick inside a fade runs execute,
// check, divide, round, output: elapsed time is formed, elapsed times distance is
// multiplied once, and a single shared subtract-and-compare unit then works out the
// 9-bit quotient by the fade length one bit per cycle. The input is not ready until
// the result has been loaded into the output register; a waiting result holds back
// the next item.
module timed_alpha_fade_ramp_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [tafr_pkg::TIME_BITS-1:0]       req_time_now,
   input  logic [tafr_pkg::LEVEL_BITS-1:0]      req_target_level,
   input  logic [tafr_pkg::DURATION_BITS-1:0]   req_duration,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tafr_pkg::LEVEL_BITS-1:0]      rsp_level,
   output logic                                 rsp_changed,
   output logic                                 rsp_fade_done,
   output logic                                 rsp_fading
);

   tafr_pkg::state_type state_ff, state_in;

   // Captured item
   tafr_pkg::mode_type                     mode_ff, mode_in;
   logic [tafr_pkg::TIME_BITS-1:0]         now_ff, now_in;
   logic [tafr_pkg::LEVEL_BITS-1:0]        target_ff, target_in;
   logic [tafr_pkg::DURATION_BITS-1:0]     dur_ff, dur_in;
   logic [tafr_pkg::LEVEL_BITS-1:0]        before_ff, before_in;

   // Fade state
   logic [tafr_pkg::LEVEL_BITS-1:0]        level_ff, level_in;
   logic                                   active_ff, active_in;
   logic [tafr_pkg::LEVEL_BITS-1:0]        goal_ff, goal_in;
   logic [tafr_pkg::DIST_BITS-1:0]         dist_ff, dist_in;
   logic [tafr_pkg::TIME_BITS-1:0]         stamp_ff, stamp_in;
   logic [tafr_pkg::DURATION_BITS-1:0]     len_ff, len_in;

   // Ramp arithmetic
   logic [tafr_pkg::CMP_W-1:0]             elapsed_ff, elapsed_in;
   logic [tafr_pkg::PROD_W-1:0]            rem_ff, rem_in;
   logic [tafr_pkg::DIVR_W-1:0]            divr_ff, divr_in;
   logic [tafr_pkg::QUOT_W-1:0]            quot_ff, quot_in;
   logic [tafr_pkg::CNT_W-1:0]             cnt_ff, cnt_in;
   logic                                   done_ff, done_in;

   // Output register
   logic                                   ovalid_ff, ovalid_in;
   logic [tafr_pkg::LEVEL_BITS-1:0]        olevel_ff, olevel_in;
   logic                                   ochanged_ff, ochanged_in;
   logic                                   odone_ff, odone_in;
   logic                                   ofading_ff, ofading_in;

   // Combinational helpers
   logic [tafr_pkg::DIST_BITS-1:0]         new_dist;
   logic                                   neg;
   logic [tafr_pkg::DIST_BITS-1:0]         mag;
   logic [tafr_pkg::PROD_W-1:0]            trial;
   logic                                   trial_ok;
   logic signed [10:0]                     start_s;
   logic signed [10:0]                     step_s;
   logic signed [10:0]                     lvl_s;
   logic [tafr_pkg::LEVEL_BITS-1:0]        lvl_clamped;

   assign req_ready     = (state_ff == tafr_pkg::ST_IDLE);
   assign rsp_valid     = ovalid_ff;
   assign rsp_level     = olevel_ff;
   assign rsp_changed   = ochanged_ff;
   assign rsp_fade_done = odone_ff;
   assign rsp_fading    = ofading_ff;

   // Shared datapath pieces
   always_comb begin
      new_dist = {1'b0, target_ff} - {1'b0, level_ff};
      neg      = dist_ff[tafr_pkg::DIST_BITS-1];
      mag      = neg ? (~dist_ff + 1'b1) : dist_ff;
      trial    = rem_ff - tafr_pkg::PROD_W'(divr_ff);
      trial_ok = (rem_ff >= tafr_pkg::PROD_W'(divr_ff));
      start_s  = $signed({3'b000, goal_ff}) - $signed({{2{dist_ff[8]}}, dist_ff});
      step_s   = $signed({2'b00, quot_ff}) + $signed({10'd0, (neg && (rem_ff != '0))});
      lvl_s    = neg ? (start_s - step_s) : (start_s + step_s);
      if (lvl_s < 0) begin
         lvl_clamped = '0;
      end else if (lvl_s > 11'sd255) begin
         lvl_clamped = 8'hFF;
      end else begin
         lvl_clamped = lvl_s[7:0];
      end
   end

   // Sequencer: next state and register updates
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      now_in      = now_ff;
      target_in   = target_ff;
      dur_in      = dur_ff;
      before_in   = before_ff;
      level_in    = level_ff;
      active_in   = active_ff;
      goal_in     = goal_ff;
      dist_in     = dist_ff;
      stamp_in    = stamp_ff;
      len_in      = len_ff;
      elapsed_in  = elapsed_ff;
      rem_in      = rem_ff;
      divr_in     = divr_ff;
      quot_in     = quot_ff;
      cnt_in      = cnt_ff;
      done_in     = done_ff;
      ovalid_in   = ovalid_ff && !rsp_ready;
      olevel_in   = olevel_ff;
      ochanged_in = ochanged_ff;
      odone_in    = odone_ff;
      ofading_in  = ofading_ff;

      case (state_ff)
         tafr_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in   = tafr_pkg::mode_type'(req_mode);
               now_in    = req_time_now;
               target_in = req_target_level;
               dur_in    = req_duration;
               before_in = level_ff;
               done_in   = 1'b0;
               state_in  = tafr_pkg::ST_EXEC;
            end
         end
         tafr_pkg::ST_EXEC: begin
            state_in = tafr_pkg::ST_OUT;
            case (mode_ff)
               tafr_pkg::MODE_TICK: begin
                  if (active_ff) begin
                     elapsed_in = (now_ff >= stamp_ff) ?
                                  tafr_pkg::CMP_W'(now_ff - stamp_ff) : '0;
                     state_in   = tafr_pkg::ST_CHECK;
                  end
               end
               tafr_pkg::MODE_FADE: begin
                  dist_in  = new_dist;
                  stamp_in = now_ff;
                  len_in   = dur_ff;
                  if ((dur_ff == '0) || (new_dist == '0)) begin
                     level_in  = target_ff;
                     active_in = 1'b0;
                     done_in   = 1'b1;
                  end else begin
                     goal_in   = target_ff;
                     active_in = 1'b1;
                  end
               end
               tafr_pkg::MODE_STOP: begin
                  active_in = 1'b0;
               end
               tafr_pkg::MODE_SET: begin
                  level_in = target_ff;
               end
               default: begin
                  state_in = tafr_pkg::ST_OUT;
               end
            endcase
         end
         tafr_pkg::ST_CHECK: begin
            // Fade complete, or set up the product for the divider
            if ((len_ff == '0) || (elapsed_ff >= tafr_pkg::CMP_W'(len_ff))) begin
               level_in  = goal_ff;
               active_in = 1'b0;
               done_in   = 1'b1;
               state_in  = tafr_pkg::ST_OUT;
            end else begin
               rem_in   = tafr_pkg::PROD_W'(elapsed_ff[tafr_pkg::DURATION_BITS-1:0] * mag);
               divr_in  = {len_ff, {(tafr_pkg::QUOT_W-1){1'b0}}};
               quot_in  = '0;
               cnt_in   = tafr_pkg::CNT_W'(tafr_pkg::QUOT_W - 1);
               state_in = tafr_pkg::ST_DIV;
            end
         end
         tafr_pkg::ST_DIV: begin
            // One restoring step per cycle, MSB of the quotient first
            if (trial_ok) begin
               rem_in = trial;
            end
            quot_in = {quot_ff[tafr_pkg::QUOT_W-2:0], trial_ok};
            divr_in = divr_ff >> 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = tafr_pkg::ST_ROUND;
            end
         end
         tafr_pkg::ST_ROUND: begin
            // Falling ramps round the step up, rising ones down
            level_in = lvl_clamped;
            state_in = tafr_pkg::ST_OUT;
         end
         tafr_pkg::ST_OUT: begin
            if (!ovalid_ff || rsp_ready) begin
               ovalid_in   = 1'b1;
               olevel_in   = level_ff;
               ochanged_in = (level_ff != before_ff);
               odone_in    = done_ff;
               ofading_in  = active_ff;
               state_in    = tafr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tafr_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and fade state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tafr_pkg::ST_IDLE;
         ovalid_ff <= 1'b0;
         level_ff  <= tafr_pkg::LEVEL_RESET;
         active_ff <= 1'b0;
         goal_ff   <= '0;
         dist_ff   <= '0;
         stamp_ff  <= '0;
         len_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         level_ff  <= level_in;
         active_ff <= active_in;
         goal_ff   <= goal_in;
         dist_ff   <= dist_in;
         stamp_ff  <= stamp_in;
         len_ff    <= len_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      target_ff   <= target_in;
      dur_ff      <= dur_in;
      before_ff   <= before_in;
      elapsed_ff  <= elapsed_in;
      rem_ff      <= rem_in;
      divr_ff     <= divr_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      done_ff     <= done_in;
      olevel_ff   <= olevel_in;
      ochanged_ff <= ochanged_in;
      odone_ff    <= odone_in;
      ofading_ff  <= ofading_in;
   end

`ifndef NO_ASSERTIONS
   // A completed fade is never still reported as running
   a_done_not_fading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fade_done && rsp_fading))
      else $error("fade_done and fading both set");

   // One item at a time: no acceptance on the cycle after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while busy");

   // The divider only runs during a fade
   a_div_needs_fade: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tafr_pkg::ST_DIV) |-> active_ff)
      else $error("divider running outside a fade");
`endif

endmodule
